/* src/card_access_table_core_defines.svh */
// Assertion macros for the card access table core.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef CARD_ACCESS_TABLE_CORE_DEFINES_SVH
`define CARD_ACCESS_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAT_ASSERT(lbl, prop, msg)
`define CAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/cat_pkg.sv */
`default_nettype none
package cat_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int ID_BITS       = 32;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);

  localparam logic [63:0]          SEED_ID  = 64'h0000_0000_99c8_a16d;
  localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

  localparam logic [2:0] OP_AUTH      = 3'd0;
  localparam logic [2:0] OP_ADD_ADMIN = 3'd1;
  localparam logic [2:0] OP_ADD_ID    = 3'd2;
  localparam logic [2:0] OP_BLOCK     = 3'd3;
  localparam logic [2:0] OP_UNBLOCK   = 3'd4;
  localparam logic [2:0] OP_REMOVE    = 3'd5;

  typedef enum logic [1:0] {
    CLS_ABSENT  = 2'd0,
    CLS_USER    = 2'd1,
    CLS_ADMIN   = 2'd2,
    CLS_BLOCKED = 2'd3
  } cls_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] card_id;
  } in_t;

  typedef struct packed {
    logic [1:0] reply;
    logic [1:0] class_after;
  } out_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    cls_t               cls;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [ID_BITS-1:0] key;
  } scan_req_t;

  typedef struct packed {
    logic                ready;
    logic                done;
    logic                hit;
    logic [IDX_BITS-1:0] hit_idx;
    cls_t                hit_cls;
    logic                free;
    logic [IDX_BITS-1:0] free_idx;
  } scan_res_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] idx;
    entry_t              entry;
  } wr_cmd_t;

endpackage
`default_nettype wire

/* src/cat_scan.sv */
`default_nettype none
module cat_scan
  import cat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire scan_req_t sreq,
  input  wire wr_cmd_t   wr,
  output scan_res_t      sres
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_t;

  entry_t mem [TABLE_ENTRIES];

  state_t              state;
  logic [IDX_BITS-1:0] addr;
  logic                data_vld;
  logic [IDX_BITS-1:0] data_idx;
  entry_t              rdata;
  logic                hit;
  logic [IDX_BITS-1:0] hit_idx;
  cls_t                hit_cls;
  logic                free;
  logic [IDX_BITS-1:0] free_idx;
  logic                done;

  logic                mem_we;
  logic [IDX_BITS-1:0] mem_waddr;
  entry_t              mem_wdata;
  logic                is_match;
  logic                is_free;

  // The clearing pass owns the write port until the table is seeded.
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = addr;
      if (addr == '0) begin
        mem_wdata = '{id: SEED_ID[ID_BITS-1:0], cls: CLS_ADMIN};
      end else begin
        mem_wdata = '{id: '0, cls: CLS_ABSENT};
      end
    end else begin
      mem_we    = wr.we;
      mem_waddr = wr.idx;
      mem_wdata = wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  // Shared compare unit: one stored entry against the key each cycle.
  assign is_free  = (rdata.cls == CLS_ABSENT);
  assign is_match = !is_free && (rdata.id == sreq.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      addr     <= '0;
      data_vld <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
      done     <= 1'b0;
    end else begin
      data_vld <= (state == S_READ);
      data_idx <= addr;
      done     <= data_vld && (data_idx == LAST_IDX);
      unique case (state)
        S_CLEAR: begin
          if (addr == LAST_IDX) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + IDX_BITS'(1);
          end
        end
        S_IDLE: begin
          addr <= '0;
          if (sreq.start) begin
            hit   <= 1'b0;
            free  <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (addr == LAST_IDX) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + IDX_BITS'(1);
          end
        end
        default: state <= S_CLEAR;
      endcase
      if (data_vld) begin
        if (is_match && !hit) begin
          hit     <= 1'b1;
          hit_idx <= data_idx;
          hit_cls <= rdata.cls;
        end
        if (is_free && !free) begin
          free     <= 1'b1;
          free_idx <= data_idx;
        end
      end
    end
  end

  assign sres.ready    = (state == S_IDLE);
  assign sres.done     = done;
  assign sres.hit      = hit;
  assign sres.hit_idx  = hit_idx;
  assign sres.hit_cls  = hit_cls;
  assign sres.free     = free;
  assign sres.free_idx = free_idx;

endmodule
`default_nettype wire

/* src/card_access_table_core.sv */
// Card access table core.
// Requests arrive on the req channel (req_valid, req_ready, req) as one word holding an
// operation code and a 32-bit card ID. Every request produces exactly one word on the rsp
// channel (rsp_valid, rsp_ready, rsp): a per-operation reply code and the class the card
// holds after the operation (absent, user, admin or blocked).
// A request is handled by scanning the whole table through one compare unit, one slot per
// cycle, from slot 0 upward. The scan records the lowest occupied slot holding the ID and the
// lowest free slot; a single write then updates the table. req_ready is low while a request
// is in flight, so only one request is in flight at a time.
// After reset the core runs a clearing pass that seeds slot 0 with the built-in admin card
// and marks all other slots absent; req_ready stays low during it.
// The response sits in an output register. The core can take the next request while the
// previous response waits; if that response is still not taken when the next one is ready,
// the core holds the new result and stays busy until rsp_ready frees the register.
`default_nettype none
`include "card_access_table_core_defines.svh"
module card_access_table_core
  import cat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire in_t  req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output out_t      rsp
);

  // Reply codes per operation.
  localparam logic [1:0] AUTH_ADMIN      = 2'd0;
  localparam logic [1:0] AUTH_USER       = 2'd1;
  localparam logic [1:0] AUTH_DENY       = 2'd2;
  localparam logic [1:0] ADM_BLOCKED     = 2'd0;
  localparam logic [1:0] ADM_ALREADY     = 2'd1;
  localparam logic [1:0] ADM_ABSENT      = 2'd2;
  localparam logic [1:0] ADM_PROMOTED    = 2'd3;
  localparam logic [1:0] ADD_BLOCKED     = 2'd0;
  localparam logic [1:0] ADD_PRESENT     = 2'd1;
  localparam logic [1:0] ADD_DONE        = 2'd2;
  localparam logic [1:0] ADD_FULL        = 2'd3;
  localparam logic [1:0] BLK_ALREADY     = 2'd0;
  localparam logic [1:0] BLK_ABSENT      = 2'd1;
  localparam logic [1:0] BLK_DONE        = 2'd2;
  localparam logic [1:0] UNB_NOT_BLOCKED = 2'd0;
  localparam logic [1:0] UNB_DONE        = 2'd1;
  localparam logic [1:0] REM_BLOCKED     = 2'd0;
  localparam logic [1:0] REM_ABSENT      = 2'd1;
  localparam logic [1:0] REM_DONE        = 2'd2;
  localparam logic [1:0] RPL_NONE        = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t    state;
  in_t       req_q;
  scan_req_t sreq;
  scan_res_t sres;
  wr_cmd_t   wr;

  logic [ID_BITS+31:0] id_ext;
  logic [ID_BITS-1:0]  key;
  logic                req_fire;
  logic                rsp_load;
  logic                scan_started;
  cls_t                cls_now;
  cls_t                cls_after;
  logic [1:0]          reply;
  logic                upd;
  logic [IDX_BITS-1:0] upd_idx;

  // The card ID is zero-extended and its low ID_BITS form the key; all 32 bits take part.
  assign id_ext = {{ID_BITS{1'b0}}, req_q.card_id};
  assign key    = id_ext[ID_BITS-1:0];

  assign req_ready = (state == ST_IDLE) && sres.ready;
  assign req_fire  = req_valid && req_ready;
  assign rsp_load  = (state == ST_RESP) && (!rsp_valid || rsp_ready);

  assign sreq.start = (state == ST_SCAN) && sres.ready && !sres.done && !scan_started;
  assign sreq.key   = key;

  cat_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .sreq (sreq),
    .wr   (wr),
    .sres (sres)
  );

  // Decide the reply and the table update from the scan result.
  always_comb begin
    cls_now   = sres.hit ? sres.hit_cls : CLS_ABSENT;
    cls_after = cls_now;
    reply     = RPL_NONE;
    upd       = 1'b0;
    upd_idx   = sres.hit_idx;
    case (req_q.operation)
      OP_AUTH: begin
        if (cls_now == CLS_ADMIN) begin
          reply = AUTH_ADMIN;
        end else if (cls_now == CLS_USER) begin
          reply = AUTH_USER;
        end else begin
          reply = AUTH_DENY;
        end
      end
      OP_ADD_ADMIN: begin
        if (cls_now == CLS_BLOCKED) begin
          reply = ADM_BLOCKED;
        end else if (cls_now == CLS_ADMIN) begin
          reply = ADM_ALREADY;
        end else if (cls_now == CLS_ABSENT) begin
          reply = ADM_ABSENT;
        end else begin
          reply     = ADM_PROMOTED;
          cls_after = CLS_ADMIN;
          upd       = 1'b1;
        end
      end
      OP_ADD_ID: begin
        if (cls_now == CLS_BLOCKED) begin
          reply = ADD_BLOCKED;
        end else if (cls_now != CLS_ABSENT) begin
          reply = ADD_PRESENT;
        end else if (sres.free) begin
          reply     = ADD_DONE;
          cls_after = CLS_USER;
          upd       = 1'b1;
          upd_idx   = sres.free_idx;
        end else begin
          reply = ADD_FULL;
        end
      end
      OP_BLOCK: begin
        if (cls_now == CLS_BLOCKED) begin
          reply = BLK_ALREADY;
        end else if (cls_now == CLS_ABSENT) begin
          reply = BLK_ABSENT;
        end else begin
          reply     = BLK_DONE;
          cls_after = CLS_BLOCKED;
          upd       = 1'b1;
        end
      end
      OP_UNBLOCK: begin
        if (cls_now != CLS_BLOCKED) begin
          reply = UNB_NOT_BLOCKED;
        end else begin
          reply     = UNB_DONE;
          cls_after = CLS_USER;
          upd       = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cls_now == CLS_BLOCKED) begin
          reply = REM_BLOCKED;
        end else if (cls_now == CLS_ABSENT) begin
          reply = REM_ABSENT;
        end else begin
          reply     = REM_DONE;
          cls_after = CLS_ABSENT;
          upd       = 1'b1;
        end
      end
      default: begin
        reply = RPL_NONE;
      end
    endcase
  end

  // The write carries the key as the stored ID; on a hit it equals the stored one.
  assign wr.we           = rsp_load && upd;
  assign wr.idx          = upd_idx;
  assign wr.entry.id     = key;
  assign wr.entry.cls    = cls_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsp_valid    <= 1'b0;
      scan_started <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            req_q        <= req;
            scan_started <= 1'b0;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sreq.start) begin
            scan_started <= 1'b1;
          end
          if (sres.done) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (rsp_load) begin
            rsp.reply       <= reply;
            rsp.class_after <= cls_after;
            rsp_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CAT_ASSERT(a_busy_after_accept, req_fire |=> !req_ready, "request accepted while busy")
  `CAT_ASSERT(a_done_in_scan, sres.done |-> (state == ST_SCAN), "scan done outside scan")
  `CAT_ASSERT(a_write_has_slot, wr.we |-> (sres.hit || sres.free), "table write without slot")
  `CAT_ASSERT_ALWAYS(a_no_rsp_after_rst, $past(rst) |-> !rsp_valid, "response after reset")

endmodule
`default_nettype wire
